FILE: rtl/ttms_pkg.sv
// Shared types, register map and constants for the timed turn motor sequencer.
// No dependencies; imported by ttms_drive and timed_turn_motor_sequencer_unit.
`timescale 1ns / 1ps
`default_nettype none

package ttms_pkg;

	localparam int DUTY_BITS_DEF  = 10;
	localparam int TIMER_BITS_DEF = 16;

	localparam int DUTY_W     = 10;
	localparam int PCT_W      = 7;
	localparam int NUM_MOTORS = 3;

	localparam int unsigned POWER_MIN_PCT = 35;
	localparam int unsigned PCT_FULL      = 100;
	localparam logic [7:0]  SINCE_MAX     = 8'd255;

	localparam logic [15:0] RUN_TICKS_RST    = 16'd720;
	localparam logic [7:0]  POWER_PCT_RST    = 8'd45;
	localparam logic [6:0]  MIN_DUTY_RST     = 7'd35;
	localparam logic [7:0]  DEBOUNCE_RST     = 8'd40;
	localparam logic [2:0]  REVERSE_MASK_RST = 3'd3;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	typedef enum logic [2:0] {
		REG_RUN_TICKS    = 3'd0,
		REG_POWER_PCT    = 3'd1,
		REG_MIN_DUTY     = 3'd2,
		REG_DEBOUNCE     = 3'd3,
		REG_REVERSE_MASK = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [15:0]       run_ticks;
		logic signed [7:0] power_percent;
		logic [6:0]        min_duty_percent;
		logic [7:0]        debounce_ticks;
		logic [2:0]        motor_reverse_mask;
	} cfg_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic              rev;
		logic              fwd;
	} chan_t;

	typedef struct packed {
		logic [2:0] pad;
		chan_t      right;
		chan_t      back;
		chan_t      left;
		logic       is_running;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/ttms_drive.sv
// H-bridge drive law for the three motor channels: direction and duty from config.
// Depends on ttms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttms_drive import ttms_pkg::*; #(
	parameter int DUTY_BITS = DUTY_BITS_DEF
) (
	input  cfg_t                   cfg,
	input  logic                   run,
	output chan_t [NUM_MOTORS-1:0] chans
);

	localparam int TabDepth = 1 << PCT_W;

	logic [7:0]        raw;
	logic [7:0]        mag;
	logic [PCT_W-1:0]  pct;
	logic [DUTY_W-1:0] duty;
	logic [DUTY_W-1:0] duty_tab [TabDepth];

	// duty = floor((2^DUTY_BITS - 1) * pct / 100), low ten bits
	for (genvar gi = 0; gi < TabDepth; gi++) begin : g_tab
		localparam int unsigned Val  = ((2 ** DUTY_BITS - 1) * gi) / PCT_FULL;
		localparam logic [31:0] ValV = 32'(Val);
		assign duty_tab[gi] = ValV[DUTY_W-1:0];
	end

	assign raw = cfg.power_percent;
	assign mag = raw[7] ? 8'(9'd256 - {1'b0, raw}) : raw;

	always_comb begin
		if (mag < 8'(POWER_MIN_PCT)) begin
			pct = PCT_W'(POWER_MIN_PCT);
		end else if (mag > 8'(PCT_FULL)) begin
			pct = PCT_W'(PCT_FULL);
		end else begin
			pct = mag[PCT_W-1:0];
		end
		if (pct < cfg.min_duty_percent) begin
			pct = cfg.min_duty_percent;
		end
		if (pct > PCT_W'(PCT_FULL)) begin
			pct = PCT_W'(PCT_FULL);
		end
	end

	assign duty = duty_tab[pct];

	always_comb begin
		for (int m = 0; m < NUM_MOTORS; m++) begin
			chans[m].fwd  = run & (~raw[7] ^ cfg.motor_reverse_mask[m]);
			chans[m].rev  = run & ~(~raw[7] ^ cfg.motor_reverse_mask[m]);
			chans[m].duty = run ? duty : '0;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/timed_turn_motor_sequencer_unit.sv
// Top level of the timed turn motor sequencer: debounce, run timer, APB registers
// and output skid buffer. Depends on ttms_pkg and ttms_drive.
//
// Usage: one request on the slave stream per 1 ms tick, s_tdata[0] carrying the
// raw active-low button level. Each request yields exactly one result on the
// master stream: run flag and three H-bridge channel drives after that tick.
// Each result is registered, via the skid register while the output stalls. One request
// per cycle is taken while s_tready is high; the debounce and run state update in a single
// pass at acceptance and the drive law is a table lookup from the registers.
// A two-entry output (result register plus skid register) lets a request be
// taken while a result waits; s_tready drops only when both entries are full,
// and rises again once m_tready moves the skid entry into the result register.
// Configuration goes through the APB port; pready is tied high, writes land on
// the access cycle. Registers at byte addresses 0x00 run_ticks, 0x04
// power_percent, 0x08 min_duty_percent, 0x0C debounce_ticks, 0x10
// motor_reverse_mask.
// Reset (arst_n low) loads register defaults, clears the run, the timers and
// both output entries, and marks the button released.
`timescale 1ns / 1ps
`default_nettype none

module timed_turn_motor_sequencer_unit import ttms_pkg::*; #(
	parameter int DUTY_BITS  = DUTY_BITS_DEF,
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,  // [0] button_level, [7:1] zero
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// [0] is_running, [1] left_fwd, [2] left_rev, [12:3] left_duty,
	// [13] back_fwd, [14] back_rev, [24:15] back_duty, [25] right_fwd,
	// [26] right_rev, [36:27] right_duty, [39:37] zero
	output logic [39:0]                m_tdata,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready
);

	localparam int CmpW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
	localparam logic [TIMER_BITS-1:0] TimerMax = {TIMER_BITS{1'b1}};

	cfg_t                  cfg_q;
	logic                  stable_level_q;
	logic [7:0]            since_change_q;
	logic                  running_q;
	logic [TIMER_BITS-1:0] run_elapsed_q;

	logic                  out_valid_q;
	result_t               out_data_q;
	logic                  skid_valid_q;
	result_t               skid_data_q;

	logic                  cfg_wr;
	reg_idx_t              reg_idx;
	logic                  in_acc;
	logic                  level;
	logic [7:0]            since_inc;
	logic                  change;
	logic                  pressed;
	logic                  started;
	logic                  run_n;
	logic [TIMER_BITS-1:0] elapsed_n;
	logic [7:0]            since_n;
	chan_t [NUM_MOTORS-1:0] chans;
	result_t               res;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

	always_comb begin
		case (reg_idx)
			REG_RUN_TICKS:    prdata = APB_DATA_W'(cfg_q.run_ticks);
			REG_POWER_PCT:    prdata = APB_DATA_W'(unsigned'(cfg_q.power_percent));
			REG_MIN_DUTY:     prdata = APB_DATA_W'(cfg_q.min_duty_percent);
			REG_DEBOUNCE:     prdata = APB_DATA_W'(cfg_q.debounce_ticks);
			REG_REVERSE_MASK: prdata = APB_DATA_W'(cfg_q.motor_reverse_mask);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.run_ticks          <= RUN_TICKS_RST;
			cfg_q.power_percent      <= POWER_PCT_RST;
			cfg_q.min_duty_percent   <= MIN_DUTY_RST;
			cfg_q.debounce_ticks     <= DEBOUNCE_RST;
			cfg_q.motor_reverse_mask <= REVERSE_MASK_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_RUN_TICKS:    cfg_q.run_ticks          <= pwdata[15:0];
				REG_POWER_PCT:    cfg_q.power_percent      <= pwdata[7:0];
				REG_MIN_DUTY:     cfg_q.min_duty_percent   <= pwdata[6:0];
				REG_DEBOUNCE:     cfg_q.debounce_ticks     <= pwdata[7:0];
				REG_REVERSE_MASK: cfg_q.motor_reverse_mask <= pwdata[2:0];
				default:          ;
			endcase
		end
	end

	// tick step: debounce, then run control
	assign s_tready  = ~skid_valid_q;
	assign in_acc    = s_tvalid & s_tready;
	assign level     = s_tdata[0];
	assign since_inc = (since_change_q == SINCE_MAX) ? since_change_q : since_change_q + 8'd1;
	assign change    = (level != stable_level_q) && (since_inc >= cfg_q.debounce_ticks);
	assign pressed   = change & ~level;
	assign since_n   = change ? 8'd0 : since_inc;

	always_comb begin
		run_n     = running_q;
		started   = 1'b0;
		elapsed_n = run_elapsed_q;
		if (pressed) begin
			if (running_q) begin
				run_n = 1'b0;
			end else if (cfg_q.run_ticks != 16'd0) begin
				run_n     = 1'b1;
				started   = 1'b1;
				elapsed_n = '0;
			end
		end
		if (run_n) begin
			if (!started && elapsed_n != TimerMax) begin
				elapsed_n = elapsed_n + 1'b1;
			end
			if (CmpW'(elapsed_n) >= CmpW'(cfg_q.run_ticks)) begin
				run_n = 1'b0;
			end
		end
	end

	ttms_drive #(
		.DUTY_BITS(DUTY_BITS)
	) u_drive (
		.cfg  (cfg_q),
		.run  (run_n),
		.chans(chans)
	);

	always_comb begin
		res.pad        = '0;
		res.is_running = run_n;
		res.left       = chans[0];
		res.back       = chans[1];
		res.right      = chans[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_level_q <= 1'b1;
			since_change_q <= 8'd0;
			running_q      <= 1'b0;
			run_elapsed_q  <= '0;
		end else if (in_acc) begin
			stable_level_q <= change ? level : stable_level_q;
			since_change_q <= since_n;
			running_q      <= run_n;
			run_elapsed_q  <= elapsed_n;
		end
	end

	// result register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_acc;
			end
		end else if (in_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			out_data_q <= skid_valid_q ? skid_data_q : res;
		end else if (in_acc) begin
			skid_data_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

FILE: tb/sv/tb_timed_turn_motor_sequencer_unit.sv
// Self-checking bench for timed_turn_motor_sequencer_unit: a directed table and
// random button runs are predicted tick by tick and compared against the output stream.
// Depends on ttms_pkg and the unit under test; no files or arguments are used.
`timescale 1ns / 1ps

module tb_timed_turn_motor_sequencer_unit;
	import ttms_pkg::*;

	localparam int IDLE_LIMIT = 5000;

	typedef struct {
		logic        is_cfg;
		reg_idx_t    idx;
		logic [31:0] val;
		logic        level;
		logic        typed;
	} step_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = 8'd0;  // [0] button_level, [7:1] zero
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// [0] is_running, [12:1] left, [24:13] back, [36:25] right (fwd, rev, duty each)
	logic [39:0]           m_tdata;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	timed_turn_motor_sequencer_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// predictor copy of registers and state
	cfg_t        regs;
	logic        db_stable;
	logic [7:0]  db_since;
	logic        run_on;
	logic [15:0] run_count;

	result_t     drive_expect_q[$];
	step_row_t   steps[$];
	int          err_count = 0;
	int          idle_cycles = 0;
	int          burst_left = 0;
	int          rx_left = 0;
	int          rx_mode = 0;
	int unsigned rx_tick = 0;

	function automatic result_t next_drive(input logic level);
		logic    pressed;
		logic    started;
		logic    positive;
		int      mag;
		result_t r;
		pressed = 1'b0;
		started = 1'b0;
		r = '0;
		if (db_since != SINCE_MAX)
			db_since = db_since + 8'd1;
		if (level != db_stable && db_since >= regs.debounce_ticks) begin
			db_stable = level;
			db_since = 8'd0;
			pressed = (level == 1'b0);
		end
		if (pressed) begin
			if (run_on) begin
				run_on = 1'b0;
			end else if (regs.run_ticks != 16'd0) begin
				run_on = 1'b1;
				started = 1'b1;
				run_count = 16'd0;
			end
		end
		if (run_on) begin
			if (!started && run_count != 16'hFFFF)
				run_count = run_count + 16'd1;
			if (run_count >= regs.run_ticks)
				run_on = 1'b0;
		end
		r.is_running = run_on;
		if (run_on) begin
			mag = $signed(regs.power_percent);
			if (mag < 0)
				mag = -mag;
			if (mag < int'(POWER_MIN_PCT))
				mag = int'(POWER_MIN_PCT);
			if (mag < int'(regs.min_duty_percent))
				mag = int'(regs.min_duty_percent);
			if (mag > int'(PCT_FULL))
				mag = int'(PCT_FULL);
			positive = ~regs.power_percent[7];
			r.left.fwd  = positive ^ regs.motor_reverse_mask[0];
			r.back.fwd  = positive ^ regs.motor_reverse_mask[1];
			r.right.fwd = positive ^ regs.motor_reverse_mask[2];
			r.left.rev  = ~r.left.fwd;
			r.back.rev  = ~r.back.fwd;
			r.right.rev = ~r.right.fwd;
			r.left.duty  = DUTY_W'((((2 ** DUTY_W) - 1) * mag) / int'(PCT_FULL));
			r.back.duty  = r.left.duty;
			r.right.duty = r.left.duty;
		end
		return r;
	endfunction

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		logic [31:0] word;
		word = $urandom;
		case (idx)
			REG_RUN_TICKS: begin
				word[15:0] = value[15:0];
				regs.run_ticks = value[15:0];
			end
			REG_POWER_PCT: begin
				word[7:0] = value[7:0];
				regs.power_percent = value[7:0];
			end
			REG_MIN_DUTY: begin
				word[6:0] = value[6:0];
				regs.min_duty_percent = value[6:0];
			end
			REG_DEBOUNCE: begin
				word[7:0] = value[7:0];
				regs.debounce_ticks = value[7:0];
			end
			default: begin
				word[2:0] = value[2:0];
				regs.motor_reverse_mask = value[2:0];
			end
		endcase
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_W'({idx, 2'b00});
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// drop the request and hold until every expected result has drained
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (drive_expect_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic hold_off(input int cycles);
		s_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic send_tick(input logic level, input logic typed);
		result_t predicted;
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, level};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = next_drive(level);
		if (typed)
			drive_expect_q.push_back(result_t'('0));
		else
			drive_expect_q.push_back(predicted);
	endtask

	task automatic paced_tick(input logic level, input logic with_gaps);
		if (burst_left == 0) begin
			if (with_gaps)
				hold_off($urandom_range(1, 6));
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		send_tick(level, 1'b0);
	endtask

	task automatic add_cfg(input reg_idx_t idx, input logic [31:0] val);
		step_row_t row;
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.val = val;
		row.level = 1'b1;
		row.typed = 1'b0;
		steps.push_back(row);
	endtask

	task automatic add_tick(input logic level, input logic typed);
		step_row_t row;
		row.is_cfg = 1'b0;
		row.idx = REG_RUN_TICKS;
		row.val = '0;
		row.level = level;
		row.typed = typed;
		steps.push_back(row);
	endtask

	// output side: stall pattern, result check and watchdog
	always @(posedge clk) begin
		result_t got;
		result_t want;
		chan_t   gc[3];
		chan_t   wc[3];
		string   names[3];
		if (arst_n) begin
			names = '{"left", "back", "right"};
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata);
				if (drive_expect_q.size() == 0) begin
					$error("result with no request waiting: %h", m_tdata);
					err_count++;
				end else begin
					want = drive_expect_q.pop_front();
					if (got.is_running !== want.is_running) begin
						$error("is_running: expected %0d, got %0d", want.is_running,
							got.is_running);
						err_count++;
					end
					gc = '{got.left, got.back, got.right};
					wc = '{want.left, want.back, want.right};
					for (int m = 0; m < 3; m++) begin
						if (gc[m].fwd !== wc[m].fwd) begin
							$error("%s_fwd: expected %0d, got %0d", names[m], wc[m].fwd,
								gc[m].fwd);
							err_count++;
						end
						if (gc[m].rev !== wc[m].rev) begin
							$error("%s_rev: expected %0d, got %0d", names[m], wc[m].rev,
								gc[m].rev);
							err_count++;
						end
						if (gc[m].duty !== wc[m].duty) begin
							$error("%s_duty: expected %0d, got %0d", names[m], wc[m].duty,
								gc[m].duty);
							err_count++;
						end
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timed_turn_motor_sequencer_unit regression: fail");
				$finish;
			end
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(50, 400);
			end
			rx_left--;
			rx_tick++;
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				2: m_tready <= ((rx_tick % 16) >= 5);
				default: m_tready <= ((rx_tick % 40) >= 20);
			endcase
		end
	end

	initial begin
		int          target;
		int          sent;
		int          seg_len;
		int          dbn;
		logic        level;
		logic        gaps;
		logic [31:0] rt;

		regs.run_ticks = RUN_TICKS_RST;
		regs.power_percent = POWER_PCT_RST;
		regs.min_duty_percent = MIN_DUTY_RST;
		regs.debounce_ticks = DEBOUNCE_RST;
		regs.motor_reverse_mask = REVERSE_MASK_RST;
		db_stable = 1'b1;
		db_since = 8'd0;
		run_on = 1'b0;
		run_count = 16'd0;

		// reset defaults: idle, then a press too early to pass the debounce
		add_tick(1'b1, 1'b1);
		add_tick(1'b0, 1'b1);
		// zero run length blocks the start
		add_cfg(REG_DEBOUNCE, 32'd0);
		add_cfg(REG_RUN_TICKS, 32'd0);
		add_tick(1'b0, 1'b1);
		add_tick(1'b1, 1'b1);
		// most negative power, min duty above full scale, run ends by itself
		add_cfg(REG_RUN_TICKS, 32'd3);
		add_cfg(REG_POWER_PCT, 32'h80);
		add_cfg(REG_MIN_DUTY, 32'd127);
		add_cfg(REG_REVERSE_MASK, 32'd5);
		add_tick(1'b0, 1'b0);
		add_tick(1'b1, 1'b0);
		add_tick(1'b1, 1'b0);
		add_tick(1'b1, 1'b1);
		add_tick(1'b1, 1'b1);
		// press while running stops at once
		add_tick(1'b0, 1'b0);
		add_tick(1'b1, 1'b0);
		add_tick(1'b0, 1'b1);
		// zero power drives positive at the floor duty
		add_cfg(REG_POWER_PCT, 32'd0);
		add_cfg(REG_MIN_DUTY, 32'd0);
		add_cfg(REG_REVERSE_MASK, 32'd0);
		add_cfg(REG_RUN_TICKS, 32'd65535);
		add_tick(1'b1, 1'b0);
		add_tick(1'b0, 1'b0);
		add_tick(1'b1, 1'b0);
		add_tick(1'b0, 1'b1);
		// largest positive power, shortest run
		add_cfg(REG_POWER_PCT, 32'h7F);
		add_cfg(REG_MIN_DUTY, 32'd100);
		add_cfg(REG_REVERSE_MASK, 32'd7);
		add_cfg(REG_RUN_TICKS, 32'd1);
		add_tick(1'b1, 1'b0);
		add_tick(1'b0, 1'b0);
		add_tick(1'b1, 1'b1);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[i]) begin
			if (steps[i].is_cfg) begin
				drain_results();
				write_reg(steps[i].idx, steps[i].val);
			end else begin
				send_tick(steps[i].level, steps[i].typed);
			end
		end

		for (int phase = 0; phase < 12; phase++) begin
			drain_results();
			case (phase)
				0: begin
					write_reg(REG_RUN_TICKS, 32'd1);
					write_reg(REG_POWER_PCT, 32'h7F);
					write_reg(REG_MIN_DUTY, 32'd0);
					write_reg(REG_DEBOUNCE, 32'd0);
					write_reg(REG_REVERSE_MASK, 32'd0);
				end
				1: begin
					write_reg(REG_RUN_TICKS, 32'd65535);
					write_reg(REG_POWER_PCT, 32'h80);
					write_reg(REG_MIN_DUTY, 32'd127);
					write_reg(REG_DEBOUNCE, 32'd255);
					write_reg(REG_REVERSE_MASK, 32'd7);
				end
				2: begin
					write_reg(REG_RUN_TICKS, 32'd0);
					write_reg(REG_DEBOUNCE, 32'd1);
				end
				default: begin
					case ($urandom_range(0, 19))
						0, 1: rt = 32'd0;
						2: rt = 32'd65535;
						3, 4, 5: rt = $urandom_range(41, 300);
						default: rt = $urandom_range(1, 40);
					endcase
					write_reg(REG_RUN_TICKS, rt);
					write_reg(REG_POWER_PCT, $urandom_range(0, 255));
					write_reg(REG_MIN_DUTY, ($urandom_range(0, 1) != 0) ?
						$urandom_range(0, 45) : $urandom_range(0, 127));
					write_reg(REG_DEBOUNCE, ($urandom_range(0, 4) != 0) ?
						$urandom_range(0, 6) : $urandom_range(0, 255));
					write_reg(REG_REVERSE_MASK, $urandom_range(0, 7));
				end
			endcase
			gaps = (phase % 3 != 0);
			burst_left = 0;
			dbn = regs.debounce_ticks;
			target = 112;
			sent = 0;
			level = db_stable;
			while (sent < target) begin
				if ($urandom_range(0, 4) != 0) begin
					// hold the opposite level long enough to pass the debounce
					level = ~level;
					seg_len = $urandom_range(dbn + 1, dbn + 10);
					repeat (seg_len) begin
						paced_tick(level, gaps);
						sent++;
					end
				end else begin
					seg_len = $urandom_range(1, 4);
					repeat (seg_len) begin
						paced_tick($urandom_range(0, 1), gaps);
						sent++;
					end
				end
				if (phase == 6 && sent >= 70 && sent < 80) begin
					drain_results();
					burst_left = 0;
				end
			end
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (err_count == 0)
			$display("timed_turn_motor_sequencer_unit regression: pass");
		else
			$display("timed_turn_motor_sequencer_unit regression: fail");
		$finish;
	end

endmodule
